// ===== hw/rtl/pfde_pkg.sv =====
`timescale 1ns / 1ps

package pfde_pkg;

	localparam int DEF_WIDTH      = 128;
	localparam int DEF_PAGES      = 4;
	localparam int DEF_GLYPH_COLS = 6;

	localparam int ROWS_PER_PAGE  = 8;
	localparam int BYTES_PER_WORD = 8;
	localparam int FONT_COLS      = 6;
	localparam int GLYPH_COUNT    = 64;

	localparam logic [7:0] FIRST_CODE = 8'h20;
	localparam logic [7:0] LAST_CODE  = 8'h5F;

	typedef enum logic [1:0] {
		KIND_PIXEL,
		KIND_CHAR,
		KIND_CLEAR,
		KIND_FLUSH
	} kind_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_PIX_RD,
		ST_PIX_WR,
		ST_CHAR,
		ST_CLEAR,
		ST_FLUSH
	} state_t;

	typedef enum logic [1:0] {
		WR_NONE,
		WR_ZERO,
		WR_PIX,
		WR_GLYPH
	} wr_op_t;

	typedef enum logic [1:0] {
		RD_NONE,
		RD_PIX,
		RD_FLUSH
	} rd_op_t;

	typedef struct packed {
		logic   cap;
		logic   cnt_clr;
		logic   cnt_inc;
		wr_op_t wr_op;
		rd_op_t rd_op;
	} dp_cmd_t;

	typedef struct packed {
		logic last_row;
		logic last_glyph;
		logic pix_ok;
		logic out_busy;
		logic out_free;
	} dp_sts_t;

	// leftmost glyph column in the top byte
	localparam logic [47:0] FONT_ROM [GLYPH_COUNT] = '{
		48'h000000000000, 48'h00005F000000,
		48'h000700070000, 48'h147F147F1400,
		48'h242A7F2A1200, 48'h231308646200,
		48'h364955225000, 48'h000503000000,
		48'h001C22410000, 48'h0041221C0000,
		48'h14083E081400, 48'h08083E080800,
		48'h005030000000, 48'h080808080800,
		48'h006060000000, 48'h201008040200,
		48'h3E5149453E00, 48'h00427F400000,
		48'h426151494600, 48'h2141454B3100,
		48'h1814127F1000, 48'h274545453900,
		48'h3C4A49493000, 48'h017109050300,
		48'h364949493600, 48'h064949291E00,
		48'h003636000000, 48'h005636000000,
		48'h081422410000, 48'h141414141400,
		48'h412214080000, 48'h020151090600,
		48'h324979413E00, 48'h7E1111117E00,
		48'h7F4949493600, 48'h3E4141412200,
		48'h7F4141221C00, 48'h7F4949494100,
		48'h7F0909090100, 48'h3E4149497A00,
		48'h7F0808087F00, 48'h00417F410000,
		48'h2040413F0100, 48'h7F0814224100,
		48'h7F4040404000, 48'h7F020C027F00,
		48'h7F0408107F00, 48'h3E4141413E00,
		48'h7F0909090600, 48'h3E4151215E00,
		48'h7F0919294600, 48'h464949493200,
		48'h01017F010100, 48'h3F4040403F00,
		48'h1F2040201F00, 48'h3F4038403F00,
		48'h631408146300, 48'h070870080700,
		48'h615149454300, 48'h007F41410000,
		48'h020408102000, 48'h0041417F0000,
		48'h040201020400, 48'h404040404000
	};

	function automatic logic [5:0] glyph_index(input logic [7:0] code);
		if (code >= FIRST_CODE && code <= LAST_CODE)
			return 6'(code - FIRST_CODE);
		return 6'd0;
	endfunction

	function automatic logic [7:0] font_col(input logic [5:0] glyph, input logic [2:0] col);
		logic [47:0] bits;
		bits = FONT_ROM[glyph];
		if (col < 3'(FONT_COLS))
			return bits[8 * (FONT_COLS - 1 - int'(col)) +: 8];
		return 8'd0;
	endfunction

endpackage

// ===== hw/rtl/page_framebuffer_draw_engine_top.sv =====
`timescale 1ns / 1ps

// Monochrome page framebuffer (WIDTH columns by PAGES pages of eight rows, one byte per
// column per page) with a 64-glyph 6x8 font. The buffer lives in a memory of 64-bit rows
// with byte write enables and one registered read port, which serves pixel reads and
// flushes. After reset the block zeroes the memory one row per cycle and accepts nothing
// until all ceil(WIDTH*PAGES/8) rows (64 at the default size) are clear. A command then
// runs: pixel as accept, read, write back (accept only when off screen); character as
// accept, then one glyph column written per cycle; clear as accept, then zeroing of every
// row as after reset; flush as accept, then one output word per cycle while the receiver
// does not stall. A flush emits ceil(WIDTH*PAGES/8) transactions, lowest address in the
// low byte, with last on the final one; the next command is taken once that word has left.
module page_framebuffer_draw_engine_top #(
	parameter int WIDTH      = pfde_pkg::DEF_WIDTH,
	parameter int PAGES      = pfde_pkg::DEF_PAGES,
	parameter int GLYPH_COLS = pfde_pkg::DEF_GLYPH_COLS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [7:0]  column,
	input  logic [7:0]  row,
	input  logic [7:0]  page,
	input  logic        color,
	input  logic [7:0]  char_code,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] pixel_bytes,
	output logic        last
);

	pfde_pkg::dp_cmd_t cmd;
	pfde_pkg::dp_sts_t sts;

	pfde_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.kind     (kind),
		.sts      (sts),
		.cmd      (cmd)
	);

	pfde_dp #(
		.WIDTH      (WIDTH),
		.PAGES      (PAGES),
		.GLYPH_COLS (GLYPH_COLS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.column      (column),
		.row         (row),
		.page        (page),
		.color       (color),
		.char_code   (char_code),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.pixel_bytes (pixel_bytes),
		.last        (last)
	);

`ifndef ASSERT_OFF
	a_no_accept_with_pending_word: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> !out_valid)
		else $error("command accepted while a flush word is pending");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("engine ready again right after a command");

	a_flush_ends_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && last) |=> !out_valid)
		else $error("output word follows the last word of a flush");
`endif

endmodule

// ===== hw/rtl/pfde_dp.sv =====
`timescale 1ns / 1ps

module pfde_dp #(
	parameter int WIDTH      = pfde_pkg::DEF_WIDTH,
	parameter int PAGES      = pfde_pkg::DEF_PAGES,
	parameter int GLYPH_COLS = pfde_pkg::DEF_GLYPH_COLS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  pfde_pkg::dp_cmd_t cmd,
	output pfde_pkg::dp_sts_t sts,
	input  logic [7:0]        column,
	input  logic [7:0]        row,
	input  logic [7:0]        page,
	input  logic              color,
	input  logic [7:0]        char_code,
	input  logic              out_stall,
	output logic              out_valid,
	output logic [63:0]       pixel_bytes,
	output logic              last
);

	localparam int STORE_BYTES = WIDTH * PAGES;
	localparam int WORDS = (STORE_BYTES + pfde_pkg::BYTES_PER_WORD - 1) /
		pfde_pkg::BYTES_PER_WORD;
	localparam int ROW_W = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int CNT_W = $clog2(WORDS + 8);
	localparam int CA_W  = 8 + $clog2(WIDTH) + 2;

	logic [63:0]     mem [WORDS];
	logic [63:0]     rdata_q;
	logic            last_q;
	logic            out_valid_q;
	logic [CNT_W-1:0] cnt_q;

	logic            pix_ok_q;
	logic [CA_W-1:0] pix_addr_q;
	logic [2:0]      pix_bit_q;
	logic            pix_color_q;
	logic [CA_W-1:0] char_base_q;
	logic [5:0]      glyph_q;

	logic            pix_in_range;
	logic [CA_W-1:0] pix_addr_d;
	logic [CA_W-1:0] char_base_d;
	logic [CA_W-1:0] glyph_addr;
	logic [7:0]      old_byte;
	logic [7:0]      bit_mask;
	logic [7:0]      new_byte;
	logic [7:0]      glyph_byte;

	logic             mem_we;
	logic [ROW_W-1:0] mem_wrow;
	logic [7:0]       mem_be;
	logic [63:0]      mem_wdata;
	logic             mem_re;
	logic [ROW_W-1:0] mem_rrow;

	always_comb begin
		pix_in_range = ({1'b0, column} < 9'(WIDTH)) &&
			({1'b0, row} < 9'(PAGES * pfde_pkg::ROWS_PER_PAGE));
		pix_addr_d   = CA_W'(column) + CA_W'(row[7:3]) * CA_W'(WIDTH);
		char_base_d  = CA_W'(column) + CA_W'(page) * CA_W'(WIDTH);
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			pix_ok_q    <= pix_in_range;
			pix_addr_q  <= pix_addr_d;
			pix_bit_q   <= row[2:0];
			pix_color_q <= color;
			char_base_q <= char_base_d;
			glyph_q     <= pfde_pkg::glyph_index(char_code);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.cnt_clr) begin
			cnt_q <= '0;
		end else if (cmd.cnt_inc) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_comb begin
		old_byte   = rdata_q[{pix_addr_q[2:0], 3'b000} +: 8];
		bit_mask   = 8'd1 << pix_bit_q;
		new_byte   = pix_color_q ? (old_byte | bit_mask) : (old_byte & ~bit_mask);
		glyph_addr = char_base_q + CA_W'(cnt_q);
		glyph_byte = pfde_pkg::font_col(glyph_q, cnt_q[2:0]);
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_wrow  = ROW_W'(cnt_q);
		mem_be    = 8'hFF;
		mem_wdata = '0;
		unique case (cmd.wr_op)
			pfde_pkg::WR_NONE: begin
				mem_we = 1'b0;
			end
			pfde_pkg::WR_ZERO: begin
				mem_we = 1'b1;
			end
			pfde_pkg::WR_PIX: begin
				mem_we    = pix_ok_q;
				mem_wrow  = ROW_W'(pix_addr_q >> 3);
				mem_be    = 8'd1 << pix_addr_q[2:0];
				mem_wdata = {8{new_byte}};
			end
			pfde_pkg::WR_GLYPH: begin
				mem_we    = glyph_addr < CA_W'(STORE_BYTES);
				mem_wrow  = ROW_W'(glyph_addr >> 3);
				mem_be    = 8'd1 << glyph_addr[2:0];
				mem_wdata = {8{glyph_byte}};
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_comb begin
		mem_re   = cmd.rd_op != pfde_pkg::RD_NONE;
		mem_rrow = (cmd.rd_op == pfde_pkg::RD_PIX) ? ROW_W'(pix_addr_q >> 3) :
			ROW_W'(cnt_q);
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			for (int b = 0; b < 8; b++) begin
				if (mem_be[b])
					mem[mem_wrow][8*b +: 8] <= mem_wdata[8*b +: 8];
			end
		end
		if (mem_re)
			rdata_q <= mem[mem_rrow];
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_op == pfde_pkg::RD_FLUSH)
			last_q <= cnt_q == CNT_W'(WORDS - 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.rd_op == pfde_pkg::RD_FLUSH) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		sts.last_row   = cnt_q == CNT_W'(WORDS - 1);
		sts.last_glyph = cnt_q == CNT_W'(GLYPH_COLS - 1);
		sts.pix_ok     = pix_ok_q;
		sts.out_busy   = out_valid_q;
		sts.out_free   = !out_valid_q || !out_stall;
	end

	assign out_valid   = out_valid_q;
	assign pixel_bytes = rdata_q;
	assign last        = last_q;

endmodule

// ===== hw/rtl/pfde_ctrl.sv =====
`timescale 1ns / 1ps

module pfde_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        kind,
	input  pfde_pkg::dp_sts_t sts,
	output pfde_pkg::dp_cmd_t cmd
);

	pfde_pkg::state_t state_q;
	pfde_pkg::state_t state_d;
	logic             accept;

	assign in_stall = (state_q != pfde_pkg::ST_IDLE) || sts.out_busy;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pfde_pkg::ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pfde_pkg::ST_INIT, pfde_pkg::ST_CLEAR: begin
				if (sts.last_row)
					state_d = pfde_pkg::ST_IDLE;
			end
			pfde_pkg::ST_IDLE: begin
				if (accept) begin
					unique case (pfde_pkg::kind_t'(kind))
						pfde_pkg::KIND_PIXEL: state_d = pfde_pkg::ST_PIX_RD;
						pfde_pkg::KIND_CHAR:  state_d = pfde_pkg::ST_CHAR;
						pfde_pkg::KIND_CLEAR: state_d = pfde_pkg::ST_CLEAR;
						pfde_pkg::KIND_FLUSH: state_d = pfde_pkg::ST_FLUSH;
					endcase
				end
			end
			pfde_pkg::ST_PIX_RD: begin
				state_d = sts.pix_ok ? pfde_pkg::ST_PIX_WR : pfde_pkg::ST_IDLE;
			end
			pfde_pkg::ST_PIX_WR: begin
				state_d = pfde_pkg::ST_IDLE;
			end
			pfde_pkg::ST_CHAR: begin
				if (sts.last_glyph)
					state_d = pfde_pkg::ST_IDLE;
			end
			pfde_pkg::ST_FLUSH: begin
				if (sts.out_free && sts.last_row)
					state_d = pfde_pkg::ST_IDLE;
			end
			default: begin
				state_d = pfde_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd.cap     = 1'b0;
		cmd.cnt_clr = 1'b0;
		cmd.cnt_inc = 1'b0;
		cmd.wr_op   = pfde_pkg::WR_NONE;
		cmd.rd_op   = pfde_pkg::RD_NONE;
		unique case (state_q)
			pfde_pkg::ST_INIT, pfde_pkg::ST_CLEAR: begin
				cmd.wr_op   = pfde_pkg::WR_ZERO;
				cmd.cnt_inc = 1'b1;
			end
			pfde_pkg::ST_IDLE: begin
				cmd.cap     = accept;
				cmd.cnt_clr = accept;
			end
			pfde_pkg::ST_PIX_RD: begin
				if (sts.pix_ok)
					cmd.rd_op = pfde_pkg::RD_PIX;
			end
			pfde_pkg::ST_PIX_WR: begin
				cmd.wr_op = pfde_pkg::WR_PIX;
			end
			pfde_pkg::ST_CHAR: begin
				cmd.wr_op   = pfde_pkg::WR_GLYPH;
				cmd.cnt_inc = 1'b1;
			end
			pfde_pkg::ST_FLUSH: begin
				if (sts.out_free) begin
					cmd.rd_op   = pfde_pkg::RD_FLUSH;
					cmd.cnt_inc = 1'b1;
				end
			end
			default: begin
				cmd.cap = 1'b0;
			end
		endcase
	end

endmodule

// ===== bench/page_framebuffer_checker.sv =====
`timescale 1ns / 1ps

module page_framebuffer_checker #(
	parameter int WIDTH      = pfde_pkg::DEF_WIDTH,
	parameter int PAGES      = pfde_pkg::DEF_PAGES,
	parameter int GLYPH_COLS = pfde_pkg::DEF_GLYPH_COLS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [7:0]  column,
	input  logic [7:0]  row,
	input  logic [7:0]  page,
	input  logic        color,
	input  logic [7:0]  char_code,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [63:0] pixel_bytes,
	input  logic        last,
	output int          errors,
	output int          pending,
	output int          words_checked
);

	localparam int STORE_BYTES = WIDTH * PAGES;
	localparam int WORD_TOTAL  = (STORE_BYTES + 7) / 8;
	localparam int DRAWN_COLS  = 6;
	localparam logic [7:0] SPACE_CODE = 8'h20;
	localparam logic [7:0] TOP_CODE   = 8'h5F;

	typedef struct packed {
		logic [63:0] bytes;
		logic        last;
	} flush_word_t;

	// glyph columns left to right, first column in the top byte
	localparam logic [47:0] GLYPH_BITS [64] = '{
		48'h000000000000, 48'h00005F000000, 48'h000700070000, 48'h147F147F1400,
		48'h242A7F2A1200, 48'h231308646200, 48'h364955225000, 48'h000503000000,
		48'h001C22410000, 48'h0041221C0000, 48'h14083E081400, 48'h08083E080800,
		48'h005030000000, 48'h080808080800, 48'h006060000000, 48'h201008040200,
		48'h3E5149453E00, 48'h00427F400000, 48'h426151494600, 48'h2141454B3100,
		48'h1814127F1000, 48'h274545453900, 48'h3C4A49493000, 48'h017109050300,
		48'h364949493600, 48'h064949291E00, 48'h003636000000, 48'h005636000000,
		48'h081422410000, 48'h141414141400, 48'h412214080000, 48'h020151090600,
		48'h324979413E00, 48'h7E1111117E00, 48'h7F4949493600, 48'h3E4141412200,
		48'h7F4141221C00, 48'h7F4949494100, 48'h7F0909090100, 48'h3E4149497A00,
		48'h7F0808087F00, 48'h00417F410000, 48'h2040413F0100, 48'h7F0814224100,
		48'h7F4040404000, 48'h7F020C027F00, 48'h7F0408107F00, 48'h3E4141413E00,
		48'h7F0909090600, 48'h3E4151215E00, 48'h7F0919294600, 48'h464949493200,
		48'h01017F010100, 48'h3F4040403F00, 48'h1F2040201F00, 48'h3F4038403F00,
		48'h631408146300, 48'h070870080700, 48'h615149454300, 48'h007F41410000,
		48'h020408102000, 48'h0041417F0000, 48'h040201020400, 48'h404040404000
	};

	logic [7:0]  frame [STORE_BYTES];
	flush_word_t words_due [$];

	task automatic plot_pixel(input logic [7:0] x, input logic [7:0] y, input logic on);
		int addr;
		if (int'(x) < WIDTH && int'(y) < PAGES * 8) begin
			addr = int'(x) + (int'(y) / 8) * WIDTH;
			frame[addr][y % 8] = on;
		end
	endtask

	task automatic plot_glyph(input logic [7:0] x, input logic [7:0] pg, input logic [7:0] code);
		int glyph;
		int addr;
		glyph = (code >= SPACE_CODE && code <= TOP_CODE) ? int'(code - SPACE_CODE) : 0;
		for (int i = 0; i < GLYPH_COLS; i++) begin
			addr = int'(x) + i + int'(pg) * WIDTH;
			if (addr < STORE_BYTES)
				frame[addr] = (i < DRAWN_COLS) ? GLYPH_BITS[glyph][47 - 8 * i -: 8] : 8'h00;
		end
	endtask

	task automatic queue_frame_words();
		flush_word_t fw;
		int addr;
		for (int w = 0; w < WORD_TOTAL; w++) begin
			fw.bytes = '0;
			for (int b = 0; b < 8; b++) begin
				addr = w * 8 + b;
				if (addr < STORE_BYTES)
					fw.bytes[8 * b +: 8] = frame[addr];
			end
			fw.last = (w == WORD_TOTAL - 1);
			words_due.push_back(fw);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : track
		int fails;
		int seen;
		flush_word_t want;
		fails = 0;
		seen = 0;
		if (!arst_n) begin
			foreach (frame[a])
				frame[a] = 8'h00;
			words_due.delete();
			errors <= 0;
			pending <= 0;
			words_checked <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				unique case (pfde_pkg::kind_t'(kind))
					pfde_pkg::KIND_PIXEL: plot_pixel(column, row, color);
					pfde_pkg::KIND_CHAR:  plot_glyph(column, page, char_code);
					pfde_pkg::KIND_CLEAR: foreach (frame[a]) frame[a] = 8'h00;
					default:              queue_frame_words();
				endcase
			end
			if (out_valid && !out_stall) begin
				seen = 1;
				if (words_due.size() == 0) begin
					$display("%0t: unexpected flush transaction, expected none, actual %h last %b",
						$time, pixel_bytes, last);
					fails++;
				end else begin
					want = words_due.pop_front();
					if (pixel_bytes !== want.bytes) begin
						$display("%0t: pixel_bytes mismatch, expected %h actual %h",
							$time, want.bytes, pixel_bytes);
						fails++;
					end
					if (last !== want.last) begin
						$display("%0t: last mismatch, expected %b actual %b",
							$time, want.last, last);
						fails++;
					end
				end
			end
			errors <= errors + fails;
			words_checked <= words_checked + seen;
			pending <= words_due.size();
		end
	end

endmodule

// ===== bench/tb_page_framebuffer_draw_engine_top.sv =====
`timescale 1ns / 1ps

module tb_page_framebuffer_draw_engine_top;

	localparam int QUIET_LIMIT  = 1000;
	localparam int PHASE_ITEMS  = 160;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  kind = pfde_pkg::KIND_PIXEL;
	logic [7:0]  column = 8'h00;
	logic [7:0]  row = 8'h00;
	logic [7:0]  page = 8'h00;
	logic        color = 1'b0;
	logic [7:0]  char_code = 8'h00;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [63:0] pixel_bytes;
	logic        last;

	int errors;
	int pending;
	int words_checked;
	int idle_pct = 14;
	int stall_pct = 55;
	int quiet_cycles = 0;
	int cmds_sent = 0;
	int flushes_sent = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	page_framebuffer_draw_engine_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.kind(kind), .column(column), .row(row), .page(page),
		.color(color), .char_code(char_code),
		.out_valid(out_valid), .out_stall(out_stall),
		.pixel_bytes(pixel_bytes), .last(last)
	);

	page_framebuffer_checker frame_check (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.kind(kind), .column(column), .row(row), .page(page),
		.color(color), .char_code(char_code),
		.out_valid(out_valid), .out_stall(out_stall),
		.pixel_bytes(pixel_bytes), .last(last),
		.errors(errors), .pending(pending), .words_checked(words_checked)
	);

	always @(posedge clk)
		out_stall <= ($urandom_range(0, 99) < stall_pct);

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb_page_framebuffer_draw_engine_top: done, errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_cmd(input pfde_pkg::kind_t k, input logic [7:0] x, input logic [7:0] y,
			input logic [7:0] pg, input logic on, input logic [7:0] code);
		int gap;
		gap = 0;
		while (gap < 30 && $urandom_range(0, 99) < idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		column <= x;
		row <= y;
		page <= pg;
		color <= on;
		char_code <= code;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		cmds_sent++;
		if (k == pfde_pkg::KIND_FLUSH)
			flushes_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic random_cmd();
		int pick;
		logic [7:0] x, y, pg, code;
		pfde_pkg::kind_t k;
		pick = $urandom_range(0, 99);
		x = 8'($urandom_range(0, 255));
		y = 8'($urandom_range(0, 255));
		pg = 8'($urandom_range(0, 255));
		code = 8'($urandom_range(0, 255));
		if (pick < 45) begin
			k = pfde_pkg::KIND_PIXEL;
			if ($urandom_range(0, 99) < 80) begin
				x = 8'($urandom_range(0, 127));
				y = 8'($urandom_range(0, 31));
			end
		end else if (pick < 85) begin
			k = pfde_pkg::KIND_CHAR;
			if ($urandom_range(0, 99) < 75)
				x = 8'($urandom_range(0, 127));
			if ($urandom_range(0, 99) < 80)
				pg = 8'($urandom_range(0, 3));
			if ($urandom_range(0, 99) < 70)
				code = 8'($urandom_range(8'h20, 8'h5F));
		end else if (pick < 89) begin
			k = pfde_pkg::KIND_CLEAR;
		end else begin
			k = pfde_pkg::KIND_FLUSH;
		end
		send_cmd(k, x, y, pg, 1'($urandom_range(0, 1)), code);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		send_cmd(pfde_pkg::KIND_FLUSH, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00);
		drain();
		send_cmd(pfde_pkg::KIND_PIXEL, 8'd0, 8'd0, 8'hFF, 1'b1, 8'hFF);
		send_cmd(pfde_pkg::KIND_PIXEL, 8'd127, 8'd31, 8'h00, 1'b1, 8'h00);
		send_cmd(pfde_pkg::KIND_PIXEL, 8'd128, 8'd0, 8'h00, 1'b1, 8'h00);
		send_cmd(pfde_pkg::KIND_PIXEL, 8'd0, 8'd32, 8'h00, 1'b1, 8'h00);
		send_cmd(pfde_pkg::KIND_PIXEL, 8'd255, 8'd255, 8'hFF, 1'b1, 8'hFF);
		send_cmd(pfde_pkg::KIND_PIXEL, 8'd5, 8'd9, 8'h00, 1'b1, 8'h00);
		send_cmd(pfde_pkg::KIND_PIXEL, 8'd0, 8'd0, 8'h00, 1'b0, 8'h00);
		send_cmd(pfde_pkg::KIND_CHAR, 8'd0, 8'hFF, 8'd0, 1'b1, 8'h5F);
		send_cmd(pfde_pkg::KIND_CHAR, 8'd6, 8'h00, 8'd0, 1'b0, 8'h20);
		send_cmd(pfde_pkg::KIND_CHAR, 8'd12, 8'h00, 8'd1, 1'b0, 8'h1F);
		send_cmd(pfde_pkg::KIND_CHAR, 8'd18, 8'h00, 8'd1, 1'b0, 8'h60);
		send_cmd(pfde_pkg::KIND_CHAR, 8'd24, 8'h00, 8'd1, 1'b0, 8'hFF);
		send_cmd(pfde_pkg::KIND_CHAR, 8'd60, 8'h00, 8'd2, 1'b0, 8'h41);
		send_cmd(pfde_pkg::KIND_CHAR, 8'd125, 8'h00, 8'd0, 1'b0, 8'h23);
		send_cmd(pfde_pkg::KIND_CHAR, 8'd126, 8'h00, 8'd3, 1'b0, 8'h57);
		send_cmd(pfde_pkg::KIND_CHAR, 8'd255, 8'h00, 8'd255, 1'b0, 8'h41);
		send_cmd(pfde_pkg::KIND_FLUSH, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00);
		drain();
		send_cmd(pfde_pkg::KIND_CLEAR, 8'hFF, 8'hFF, 8'hFF, 1'b1, 8'hFF);
		send_cmd(pfde_pkg::KIND_FLUSH, 8'hFF, 8'hFF, 8'hFF, 1'b1, 8'hFF);
		send_cmd(pfde_pkg::KIND_PIXEL, 8'd64, 8'd16, 8'h00, 1'b1, 8'h00);
		send_cmd(pfde_pkg::KIND_FLUSH, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00);
		drain();

		for (int ph = 0; ph < 3; ph++) begin
			idle_pct = (ph == 0) ? 14 : (ph == 1) ? 55 : 0;
			stall_pct = (ph == 0) ? 55 : (ph == 1) ? 14 : 0;
			repeat (PHASE_ITEMS) begin
				random_cmd();
				if ($urandom_range(0, 99) < 3)
					drain();
			end
			drain();
		end

		repeat (20) @(posedge clk);
		$display("%0d commands sent, %0d of them flushes; %0d flush words checked",
			cmds_sent, flushes_sent, words_checked);
		if (errors == 0 && pending == 0)
			$display("tb_page_framebuffer_draw_engine_top: done, clean");
		else
			$display("tb_page_framebuffer_draw_engine_top: done, errors");
		$finish;
	end

endmodule

// ===== page_framebuffer_draw_engine_top.f =====
hw/rtl/pfde_pkg.sv
hw/rtl/pfde_dp.sv
hw/rtl/pfde_ctrl.sv
hw/rtl/page_framebuffer_draw_engine_top.sv
bench/page_framebuffer_checker.sv
bench/tb_page_framebuffer_draw_engine_top.sv
